### sv/brush_falloff_weight_max_assert.svh
`ifndef BRUSH_FALLOFF_WEIGHT_MAX_ASSERT_SVH
`define BRUSH_FALLOFF_WEIGHT_MAX_ASSERT_SVH

// same-cycle implication, off during reset
`define BFWM_ASSERT_HOLD(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define BFWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bfwm_pkg.sv
package bfwm_pkg;

  localparam int OFS_W      = 20;
  localparam int PREV_W     = 17;
  localparam int WEIGHT_W   = 17;
  localparam int SCALED_W   = 24;
  localparam int RAD_W      = 20;
  localparam int STR_W      = 16;
  localparam int STR_FRAC_W = 8;
  localparam int SHAPE_W    = 2;
  localparam int FRAC_W     = 16;
  localparam int DIST_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [WEIGHT_W-1:0] ONE        = WEIGHT_W'(1 << FRAC_W);
  localparam logic [SCALED_W-1:0] SCALED_MAX = '1;

  localparam logic [SHAPE_W-1:0] SHAPE_LINEAR = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_SMOOTH = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_SPHERE = 2'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_TIP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SHAPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd3;

  localparam logic [SHAPE_W-1:0] RST_SHAPE    = SHAPE_LINEAR;
  localparam logic [RAD_W-1:0]   RST_INNER    = 20'd2560;
  localparam logic [RAD_W-1:0]   RST_WIDTH    = 20'd0;
  localparam logic [STR_W-1:0]   RST_STRENGTH = 16'd256;

endpackage

### sv/bfwm_if.sv
interface bfwm_in_if import bfwm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OFS_W-1:0]    offset_x;
  logic signed [OFS_W-1:0]    offset_z;
  logic        [PREV_W-1:0]   prev_weight;

  modport source(output valid, output offset_x, output offset_z, output prev_weight,
                 input ready);
  modport sink(input valid, input offset_x, input offset_z, input prev_weight,
               output ready);
endinterface

interface bfwm_out_if import bfwm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [WEIGHT_W-1:0]   weight;
  logic [SCALED_W-1:0]   scaled_weight;

  modport source(output valid, output weight, output scaled_weight, input ready);
  modport sink(input valid, input weight, input scaled_weight, output ready);
endinterface

### sv/bfwm_pipe_reg.sv
module bfwm_pipe_reg #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      out_data <= in_data;
    end
  end

endmodule

### sv/bfwm_isqrt.sv
module bfwm_isqrt import bfwm_pkg::*; #(
  parameter int W  = DIST_W,
  parameter int SW = WEIGHT_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2*W-1:0]  in_val,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [W-1:0]    out_root,
  output logic [SW-1:0]   out_side
);

  // one root bit per stage
  logic [W:0]       en;
  logic [W-1:0]     vq;
  logic [2*W-1:0]   val_q  [W];
  logic [W+1:0]     rem_q  [W];
  logic [W-1:0]     root_q [W];
  logic [SW-1:0]    side_q [W];

  assign en[W] = out_ready;

  generate
    for (genvar k = 0; k < W; k++) begin : g_stage
      logic [2*W-1:0] v_in;
      logic [W+1:0]   r_in;
      logic [W-1:0]   q_in;
      logic [SW-1:0]  s_in;
      logic           ok_in;
      logic [W+1:0]   r_sh;
      logic [W+1:0]   trial;
      logic [W+1:0]   r_out;
      logic           take;

      if (k == 0) begin : g_first
        assign v_in  = in_val;
        assign r_in  = '0;
        assign q_in  = '0;
        assign s_in  = in_side;
        assign ok_in = in_valid;
      end else begin : g_next
        assign v_in  = val_q[k-1];
        assign r_in  = rem_q[k-1];
        assign q_in  = root_q[k-1];
        assign s_in  = side_q[k-1];
        assign ok_in = vq[k-1];
      end

      assign en[k] = !vq[k] || en[k+1];
      assign r_sh  = {r_in[W-1:0], v_in[2*W-1 -: 2]};
      assign trial = {q_in, 2'b01};
      assign take  = r_sh >= trial;
      assign r_out = take ? r_sh - trial : r_sh;

      always_ff @(posedge clk) begin
        if (rst) begin
          vq[k] <= 1'b0;
        end else if (en[k]) begin
          vq[k] <= ok_in;
        end
        if (en[k]) begin
          val_q[k]  <= {v_in[2*W-3:0], 2'b00};
          rem_q[k]  <= r_out;
          root_q[k] <= {q_in[W-2:0], take};
          side_q[k] <= s_in;
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = vq[W-1];
  assign out_root  = root_q[W-1];
  assign out_side  = side_q[W-1];

endmodule

### sv/bfwm_div.sv
module bfwm_div import bfwm_pkg::*; #(
  parameter int QW = FRAC_W + 1,
  parameter int DW = RAD_W,
  parameter int SW = WEIGHT_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  // restoring division, one quotient bit per stage; in_rem must be below in_div
  logic [QW:0]     en;
  logic [QW-1:0]   vq;
  logic [DW-1:0]   rem_q  [QW];
  logic [QW-1:0]   low_q  [QW];
  logic [DW-1:0]   div_q  [QW];
  logic [QW-1:0]   quot_q [QW];
  logic [SW-1:0]   side_q [QW];

  assign en[QW] = out_ready;

  generate
    for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] r_in;
      logic [QW-1:0] l_in;
      logic [DW-1:0] d_in;
      logic [QW-1:0] q_in;
      logic [SW-1:0] s_in;
      logic          ok_in;
      logic [DW:0]   r2;
      logic [DW:0]   r_out;
      logic          take;

      if (k == 0) begin : g_first
        assign r_in  = in_rem;
        assign l_in  = in_low;
        assign d_in  = in_div;
        assign q_in  = '0;
        assign s_in  = in_side;
        assign ok_in = in_valid;
      end else begin : g_next
        assign r_in  = rem_q[k-1];
        assign l_in  = low_q[k-1];
        assign d_in  = div_q[k-1];
        assign q_in  = quot_q[k-1];
        assign s_in  = side_q[k-1];
        assign ok_in = vq[k-1];
      end

      assign en[k] = !vq[k] || en[k+1];
      assign r2    = {r_in, l_in[QW-1]};
      assign take  = r2 >= {1'b0, d_in};
      assign r_out = take ? r2 - {1'b0, d_in} : r2;

      always_ff @(posedge clk) begin
        if (rst) begin
          vq[k] <= 1'b0;
        end else if (en[k]) begin
          vq[k] <= ok_in;
        end
        if (en[k]) begin
          rem_q[k]  <= r_out[DW-1:0];
          low_q[k]  <= {l_in[QW-2:0], 1'b0};
          div_q[k]  <= d_in;
          quot_q[k] <= {q_in[QW-2:0], take};
          side_q[k] <= s_in;
        end
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = vq[QW-1];
  assign out_quot  = quot_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule

### sv/brush_falloff_weight_max.sv
// Throughput: one transaction per cycle while the output accepts; every unit is fully pipelined, the
// distance root, the ring divider and the circle root each resolve one bit per stage.
// Ready is combinational through all stages; bubbles are squeezed out while the output waits.
// Reset (rst, synchronous): all valid bits cleared, configuration registers return to defaults.
module brush_falloff_weight_max import bfwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bfwm_in_if.sink               sample_in,
  bfwm_out_if.source            result_out
);

  localparam int MAG_W  = OFS_W;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int Q_W    = FRAC_W + 1;
  localparam int TSQ_W  = 2 * Q_W;
  localparam int K_W    = Q_W + 1;
  localparam int P_W    = TSQ_W + K_W;
  localparam int S_W    = P_W - 2 * FRAC_W;
  localparam int PROD_W = WEIGHT_W + STR_W;

  localparam logic [TSQ_W-1:0] CIRCLE_ONE = TSQ_W'(64'd1 << (2 * FRAC_W));
  localparam logic [K_W-1:0]   SMOOTH_K   = K_W'(3 * (1 << FRAC_W));
  localparam logic [P_W-1:0]   ROUND_HALF = P_W'(64'd1 << (2 * FRAC_W - 1));

  localparam logic [1:0] MODE_FULL = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_CALC = 2'd2;

  typedef struct packed {
    logic [MAG_W-1:0]    ax;
    logic [MAG_W-1:0]    az;
    logic [WEIGHT_W-1:0] prev;
  } mag_t;

  typedef struct packed {
    logic [SQ_W-1:0]     xx;
    logic [SQ_W-1:0]     zz;
    logic [WEIGHT_W-1:0] prev;
  } sq_t;

  typedef struct packed {
    logic [SQ_W-1:0]     sum;
    logic [WEIGHT_W-1:0] prev;
  } sum_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic [WEIGHT_W-1:0] prev;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0] n;
    side_t            side;
  } prep_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    side_t          side;
  } qside_t;

  typedef struct packed {
    logic [TSQ_W-1:0] tt;
    qside_t           qs;
  } tsq_t;

  typedef struct packed {
    logic [TSQ_W-1:0] cv;
    qside_t           qs;
  } circ_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] y;
    logic [WEIGHT_W-1:0] w_oth;
    logic [WEIGHT_W-1:0] prev;
  } wt_t;

  typedef struct packed {
    logic [TSQ_W-1:0]    yy;
    logic [K_W-1:0]      k;
    logic [WEIGHT_W-1:0] w_oth;
    logic [WEIGHT_W-1:0] prev;
  } sm1_t;

  typedef struct packed {
    logic [P_W-1:0]      p;
    logic [WEIGHT_W-1:0] w_oth;
    logic [WEIGHT_W-1:0] prev;
  } sm2_t;

  typedef struct packed {
    logic [PROD_W-1:0]   prod;
    logic [WEIGHT_W-1:0] w;
  } prod_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [SCALED_W-1:0] scaled;
  } res_t;

  // configuration
  logic [SHAPE_W-1:0] falloff_shape;
  logic [RAD_W-1:0]   inner_radius;
  logic [RAD_W-1:0]   falloff_width;
  logic [STR_W-1:0]   strength;
  logic               ring_shape;

  always_ff @(posedge clk) begin
    if (rst) begin
      falloff_shape <= RST_SHAPE;
      inner_radius  <= RST_INNER;
      falloff_width <= RST_WIDTH;
      strength      <= RST_STRENGTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPE:    falloff_shape <= cfg_data[SHAPE_W-1:0];
        REG_INNER:    inner_radius  <= cfg_data[RAD_W-1:0];
        REG_WIDTH:    falloff_width <= cfg_data[RAD_W-1:0];
        REG_STRENGTH: strength      <= cfg_data[STR_W-1:0];
      endcase
    end
  end

  assign ring_shape = (falloff_shape == SHAPE_SPHERE) || (falloff_shape == SHAPE_TIP);

  // stage 1: magnitudes, clamp previous weight
  mag_t s1_d, s1_q;
  logic s1_v;
  logic s2_rdy;

  always_comb begin
    s1_d.ax   = sample_in.offset_x[OFS_W-1] ? MAG_W'(-sample_in.offset_x)
                                            : MAG_W'(sample_in.offset_x);
    s1_d.az   = sample_in.offset_z[OFS_W-1] ? MAG_W'(-sample_in.offset_z)
                                            : MAG_W'(sample_in.offset_z);
    s1_d.prev = (sample_in.prev_weight > ONE) ? ONE : sample_in.prev_weight;
  end

  bfwm_pipe_reg #(.W($bits(mag_t))) u_s1 (
    .clk, .rst,
    .in_valid(sample_in.valid), .in_ready(sample_in.ready), .in_data(s1_d),
    .out_valid(s1_v), .out_ready(s2_rdy), .out_data(s1_q)
  );

  // stage 2: squares
  sq_t  s2_d, s2_q;
  logic s2_v;
  logic s3_rdy;

  always_comb begin
    s2_d.xx   = s1_q.ax * s1_q.ax;
    s2_d.zz   = s1_q.az * s1_q.az;
    s2_d.prev = s1_q.prev;
  end

  bfwm_pipe_reg #(.W($bits(sq_t))) u_s2 (
    .clk, .rst,
    .in_valid(s1_v), .in_ready(s2_rdy), .in_data(s2_d),
    .out_valid(s2_v), .out_ready(s3_rdy), .out_data(s2_q)
  );

  // stage 3: sum of squares
  sum_t s3_d, s3_q;
  logic s3_v;
  logic r1_rdy;

  always_comb begin
    s3_d.sum  = s2_q.xx + s2_q.zz;
    s3_d.prev = s2_q.prev;
  end

  bfwm_pipe_reg #(.W($bits(sum_t))) u_s3 (
    .clk, .rst,
    .in_valid(s2_v), .in_ready(s3_rdy), .in_data(s3_d),
    .out_valid(s3_v), .out_ready(r1_rdy), .out_data(s3_q)
  );

  // distance root
  logic [DIST_W-1:0]   root_dist;
  logic [WEIGHT_W-1:0] r1_prev;
  logic                r1_v;
  logic                s4_rdy;

  bfwm_isqrt #(.W(DIST_W), .SW(WEIGHT_W)) u_dist_root (
    .clk, .rst,
    .in_valid(s3_v), .in_ready(r1_rdy), .in_val(s3_q.sum), .in_side(s3_q.prev),
    .out_valid(r1_v), .out_ready(s4_rdy), .out_root(root_dist), .out_side(r1_prev)
  );

  // stage 4: region decision and ring numerator
  prep_t          s4_d, s4_q;
  logic           s4_v;
  logic           dv_rdy;
  logic [RAD_W:0] rf;
  logic [RAD_W:0] dist_e;
  logic [RAD_W:0] tip_n;
  logic [RAD_W-1:0] lin_n;
  logic           full;
  logic           zero;

  always_comb begin
    rf     = {1'b0, inner_radius} + {1'b0, falloff_width};
    dist_e = {1'b0, root_dist};
    tip_n  = rf - dist_e;
    lin_n  = root_dist - inner_radius;
    if (ring_shape) begin
      full = root_dist <= inner_radius;
      zero = (falloff_width == '0) || (dist_e > rf);
    end else begin
      full = root_dist < inner_radius;
      zero = (falloff_width == '0) || (dist_e >= rf);
    end
    priority if (full) begin
      s4_d.side.mode = MODE_FULL;
    end else if (zero) begin
      s4_d.side.mode = MODE_ZERO;
    end else begin
      s4_d.side.mode = MODE_CALC;
    end
    s4_d.n         = (falloff_shape == SHAPE_TIP) ? tip_n[RAD_W-1:0] : lin_n;
    s4_d.side.prev = r1_prev;
  end

  bfwm_pipe_reg #(.W($bits(prep_t))) u_s4 (
    .clk, .rst,
    .in_valid(r1_v), .in_ready(s4_rdy), .in_data(s4_d),
    .out_valid(s4_v), .out_ready(dv_rdy), .out_data(s4_q)
  );

  // ring position t = n / width in Q0.16
  logic [Q_W-1:0] quot;
  side_t          dv_side;
  logic           dv_v;
  logic           s5_rdy;

  bfwm_div #(.QW(Q_W), .DW(RAD_W), .SW($bits(side_t))) u_ring_div (
    .clk, .rst,
    .in_valid(s4_v), .in_ready(dv_rdy),
    .in_rem({1'b0, s4_q.n[RAD_W-1:1]}), .in_low({s4_q.n[0], {FRAC_W{1'b0}}}),
    .in_div(falloff_width), .in_side(s4_q.side),
    .out_valid(dv_v), .out_ready(s5_rdy), .out_quot(quot), .out_side(dv_side)
  );

  // stage 5: t squared
  tsq_t s5_d, s5_q;
  logic s5_v;
  logic s6_rdy;

  always_comb begin
    s5_d.tt      = quot * quot;
    s5_d.qs.q    = quot;
    s5_d.qs.side = dv_side;
  end

  bfwm_pipe_reg #(.W($bits(tsq_t))) u_s5 (
    .clk, .rst,
    .in_valid(dv_v), .in_ready(s5_rdy), .in_data(s5_d),
    .out_valid(s5_v), .out_ready(s6_rdy), .out_data(s5_q)
  );

  // stage 6: one minus t squared
  circ_t s6_d, s6_q;
  logic  s6_v;
  logic  r2_rdy;

  always_comb begin
    s6_d.cv = CIRCLE_ONE - s5_q.tt;
    s6_d.qs = s5_q.qs;
  end

  bfwm_pipe_reg #(.W($bits(circ_t))) u_s6 (
    .clk, .rst,
    .in_valid(s5_v), .in_ready(s6_rdy), .in_data(s6_d),
    .out_valid(s6_v), .out_ready(r2_rdy), .out_data(s6_q)
  );

  // circle root
  logic [Q_W-1:0] circ;
  qside_t         r2_qs;
  logic           r2_v;
  logic           s7_rdy;

  bfwm_isqrt #(.W(Q_W), .SW($bits(qside_t))) u_circle_root (
    .clk, .rst,
    .in_valid(s6_v), .in_ready(r2_rdy), .in_val(s6_q.cv), .in_side(s6_q.qs),
    .out_valid(r2_v), .out_ready(s7_rdy), .out_root(circ), .out_side(r2_qs)
  );

  // stage 7: shape weights
  wt_t                 s7_d, s7_q;
  logic                s7_v;
  logic                s8_rdy;
  logic [WEIGHT_W-1:0] ring_w;

  always_comb begin
    unique case (r2_qs.side.mode)
      MODE_FULL: begin
        s7_d.y = ONE;
        ring_w = ONE;
      end
      MODE_ZERO: begin
        s7_d.y = '0;
        ring_w = '0;
      end
      default: begin
        s7_d.y = ONE - r2_qs.q;
        ring_w = (falloff_shape == SHAPE_TIP) ? ONE - circ : circ;
      end
    endcase
    s7_d.w_oth = ring_shape ? ring_w : s7_d.y;
    s7_d.prev  = r2_qs.side.prev;
  end

  bfwm_pipe_reg #(.W($bits(wt_t))) u_s7 (
    .clk, .rst,
    .in_valid(r2_v), .in_ready(s7_rdy), .in_data(s7_d),
    .out_valid(s7_v), .out_ready(s8_rdy), .out_data(s7_q)
  );

  // stage 8: smoothstep, y squared and 3 - 2y
  sm1_t s8_d, s8_q;
  logic s8_v;
  logic s9_rdy;

  always_comb begin
    s8_d.yy    = s7_q.y * s7_q.y;
    s8_d.k     = SMOOTH_K - {s7_q.y, 1'b0};
    s8_d.w_oth = s7_q.w_oth;
    s8_d.prev  = s7_q.prev;
  end

  bfwm_pipe_reg #(.W($bits(sm1_t))) u_s8 (
    .clk, .rst,
    .in_valid(s7_v), .in_ready(s8_rdy), .in_data(s8_d),
    .out_valid(s8_v), .out_ready(s9_rdy), .out_data(s8_q)
  );

  // stage 9: smoothstep product
  sm2_t s9_d, s9_q;
  logic s9_v;
  logic s10_rdy;

  always_comb begin
    s9_d.p     = s8_q.yy * s8_q.k;
    s9_d.w_oth = s8_q.w_oth;
    s9_d.prev  = s8_q.prev;
  end

  bfwm_pipe_reg #(.W($bits(sm2_t))) u_s9 (
    .clk, .rst,
    .in_valid(s8_v), .in_ready(s9_rdy), .in_data(s9_d),
    .out_valid(s9_v), .out_ready(s10_rdy), .out_data(s9_q)
  );

  // stage 10: round, select, running maximum
  logic [WEIGHT_W-1:0] s10_d, s10_q;
  logic                s10_v;
  logic                s11_rdy;
  logic [P_W-1:0]      p_rnd;
  logic [S_W-1:0]      sm_raw;
  logic [WEIGHT_W-1:0] sm_w;
  logic [WEIGHT_W-1:0] w_new;

  always_comb begin
    p_rnd  = s9_q.p + ROUND_HALF;
    sm_raw = p_rnd[P_W-1:2*FRAC_W];
    sm_w   = (sm_raw > S_W'(ONE)) ? ONE : sm_raw[WEIGHT_W-1:0];
    w_new  = (falloff_shape == SHAPE_SMOOTH) ? sm_w : s9_q.w_oth;
    s10_d  = (w_new > s9_q.prev) ? w_new : s9_q.prev;
  end

  bfwm_pipe_reg #(.W(WEIGHT_W)) u_s10 (
    .clk, .rst,
    .in_valid(s9_v), .in_ready(s10_rdy), .in_data(s10_d),
    .out_valid(s10_v), .out_ready(s11_rdy), .out_data(s10_q)
  );

  // stage 11: strength product
  prod_t s11_d, s11_q;
  logic  s11_v;
  logic  s12_rdy;

  always_comb begin
    s11_d.prod = s10_q * strength;
    s11_d.w    = s10_q;
  end

  bfwm_pipe_reg #(.W($bits(prod_t))) u_s11 (
    .clk, .rst,
    .in_valid(s10_v), .in_ready(s11_rdy), .in_data(s11_d),
    .out_valid(s11_v), .out_ready(s12_rdy), .out_data(s11_q)
  );

  // stage 12: scale, saturate, output register
  res_t                         s12_d, s12_q;
  logic [PROD_W-STR_FRAC_W-1:0] scaled_full;

  always_comb begin
    scaled_full   = s11_q.prod[PROD_W-1:STR_FRAC_W];
    s12_d.scaled  = (scaled_full > {1'b0, SCALED_MAX}) ? SCALED_MAX
                                                       : scaled_full[SCALED_W-1:0];
    s12_d.weight  = s11_q.w;
  end

  bfwm_pipe_reg #(.W($bits(res_t))) u_s12 (
    .clk, .rst,
    .in_valid(s11_v), .in_ready(s12_rdy), .in_data(s12_d),
    .out_valid(result_out.valid), .out_ready(result_out.ready), .out_data(s12_q)
  );

  assign result_out.weight        = s12_q.weight;
  assign result_out.scaled_weight = s12_q.scaled;

endmodule

### sv/bfwm_chk.sv
`include "brush_falloff_weight_max_assert.svh"

module bfwm_chk import bfwm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [WEIGHT_W-1:0] weight,
  input logic [SCALED_W-1:0] scaled_weight
);

  `BFWM_ASSERT_HOLD(a_weight_range, out_valid, weight <= ONE, "weight above one")
  `BFWM_ASSERT_HOLD(a_zero_scaled, out_valid && (weight == '0), scaled_weight == '0,
    "scaled weight without weight")
  `BFWM_ASSERT_HOLD(a_drained_ready, !out_valid, in_ready,
    "empty pipeline refuses a transaction")
  `BFWM_ASSERT_NEXT(a_reset_empty, rst, !out_valid, "result valid after reset")
  `BFWM_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready && !rst,
    out_valid && $stable(weight) && $stable(scaled_weight), "stalled result changed")

endmodule

bind brush_falloff_weight_max bfwm_chk u_bfwm_chk (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (sample_in.ready),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .weight        (result_out.weight),
  .scaled_weight (result_out.scaled_weight)
);
